### hw/rtl/rbf_pkg.sv
// ----------------------------------------------------------------------------
// rbf_pkg
// Shared constants, register codes and the per-axis control struct of the
// ring bending force block.
// ----------------------------------------------------------------------------
package rbf_pkg;

  localparam int MAX_NODES = 64;
  localparam int ADDR_W    = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
  localparam int CNT_W     = $clog2(MAX_NODES + 1);
  // reads per ring: every node plus two on each side of the wrap
  localparam int RD_W      = $clog2(MAX_NODES + 5);

  localparam int POS_W   = 24;
  localparam int FORCE_W = 32;
  localparam int STIFF_W = 24;
  localparam int CAP_W   = 31;
  localparam int DATA_W  = 2 * POS_W + 2 * FORCE_W;

  // d2 = p + n - 2c, stiffness is unsigned Q16, d2 is Q9: Q25 -> Q8
  localparam int D2_W     = POS_W + 2;
  localparam int PROD_W   = STIFF_W + 1 + D2_W;
  localparam int PROD_SH  = 17;
  localparam int SCALED_W = PROD_W - PROD_SH;
  localparam int SUM_W    = FORCE_W + 3;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = CAP_W;

  localparam logic [CFG_IDX_W-1:0] CFG_BEND_STIFFNESS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FORCE_CAP      = 2'd1;

  localparam logic [CAP_W-1:0] CAP_RESET = 31'd25600;

  typedef struct packed {
    logic pos_shift;
    logic d2_load;
    logic prod_load;
    logic f_load;
    logic f_shift;
    logic out_load;
  } axis_ctrl_t;

endpackage

### hw/rtl/rbf_ram.sv
// ----------------------------------------------------------------------------
// rbf_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module rbf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### hw/rtl/rbf_axis.sv
// ----------------------------------------------------------------------------
// rbf_axis
// One axis of the bending datapath: position window, second difference,
// stiffness multiply, floor and clamp, force window and saturating output sum.
// ----------------------------------------------------------------------------
module rbf_axis (
  input  logic                                clk_i,
  input  rbf_pkg::axis_ctrl_t                 ctrl_i,
  input  logic signed [rbf_pkg::POS_W-1:0]    pos_i,
  input  logic signed [rbf_pkg::FORCE_W-1:0]  force_i,
  input  logic [rbf_pkg::STIFF_W-1:0]         stiff_i,
  input  logic [rbf_pkg::CAP_W-1:0]           cap_i,
  output logic signed [rbf_pkg::FORCE_W-1:0]  force_o
);

  localparam int PW = rbf_pkg::POS_W;
  localparam int FW = rbf_pkg::FORCE_W;
  localparam int DW = rbf_pkg::D2_W;
  localparam int MW = rbf_pkg::PROD_W;
  localparam int SW = rbf_pkg::SCALED_W;
  localparam int UW = rbf_pkg::SUM_W;

  // position window: pos0 is the node whose force is formed next
  logic signed [PW-1:0] pos0_q, pos1_q;
  logic signed [FW-1:0] pfrc0_q;
  logic signed [DW-1:0] d2_d, d2_q;
  logic signed [FW-1:0] dfrc_q;
  logic signed [MW-1:0] prod_d, prod_q;
  logic signed [FW-1:0] mfrc_q;
  logic signed [SW-1:0] scaled, cap_pos, cap_neg, clamped;
  logic signed [FW-1:0] f_d, f_q, ffrc_q;
  logic signed [FW-1:0] fw0_q, fw1_q, wfrc0_q;
  logic signed [UW-1:0] sum;
  logic signed [FW-1:0] out_d, out_q;

  assign d2_d = {{2{pos1_q[PW-1]}}, pos1_q} + {{2{pos_i[PW-1]}}, pos_i}
              - {pos0_q[PW-1], pos0_q, 1'b0};

  assign prod_d = $signed({1'b0, stiff_i}) * d2_q;

  // arithmetic shift of the product is the floor toward minus infinity
  assign scaled  = prod_q[MW-1:rbf_pkg::PROD_SH];
  assign cap_pos = $signed({{(SW - rbf_pkg::CAP_W){1'b0}}, cap_i});
  assign cap_neg = -cap_pos;

  always_comb begin
    priority if (scaled > cap_pos) begin
      clamped = cap_pos;
    end else if (scaled < cap_neg) begin
      clamped = cap_neg;
    end else begin
      clamped = scaled;
    end
  end

  assign f_d = clamped[FW-1:0];

  // center fw0 gets its own force, minus half of each neighbor's
  assign sum = {{(UW-FW){wfrc0_q[FW-1]}}, wfrc0_q}
             + {{(UW-FW){fw0_q[FW-1]}}, fw0_q}
             - {{(UW-FW+1){fw1_q[FW-1]}}, fw1_q[FW-1:1]}
             - {{(UW-FW+1){f_q[FW-1]}}, f_q[FW-1:1]};

  always_comb begin
    priority if (!sum[UW-1] && (sum[UW-2:FW-1] != '0)) begin
      out_d = {1'b0, {(FW-1){1'b1}}};
    end else if (sum[UW-1] && (sum[UW-2:FW-1] != '1)) begin
      out_d = {1'b1, {(FW-1){1'b0}}};
    end else begin
      out_d = sum[FW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.pos_shift) begin
      pos1_q  <= pos0_q;
      pos0_q  <= pos_i;
      pfrc0_q <= force_i;
    end
    if (ctrl_i.d2_load) begin
      d2_q   <= d2_d;
      dfrc_q <= pfrc0_q;
    end
    if (ctrl_i.prod_load) begin
      prod_q <= prod_d;
      mfrc_q <= dfrc_q;
    end
    if (ctrl_i.f_load) begin
      f_q    <= f_d;
      ffrc_q <= mfrc_q;
    end
    if (ctrl_i.f_shift) begin
      fw1_q   <= fw0_q;
      fw0_q   <= f_q;
      wfrc0_q <= ffrc_q;
    end
    if (ctrl_i.out_load) begin
      out_q <= out_d;
    end
  end

  assign force_o = out_q;

endmodule

### hw/rtl/ring_bending_force_top.sv
// ----------------------------------------------------------------------------
// ring_bending_force_top
// Loads a closed ring of nodes into one RAM, then sweeps the RAM once and
// emits the bending-updated force of every node in load order.
//
//   channel | signals                                   | flow control
//   --------+-------------------------------------------+------------------
//   node    | start, node_*_i, force_in_*_i, last_node_i | start & !busy
//   result  | strobe_o, force_out_*_o, last_out_o        | strobe, no stall
//   config  | cfg_we_i, cfg_idx_i, cfg_data_i            | write enable
//
// Loading takes one node per cycle. After the last node, busy is high while
// the ring of n nodes is swept: n + 4 RAM reads through a five-stage datapath,
// so the n results appear back to back; busy drops with the final result.
// Reset clears the node count and control and sets the configuration to its
// defaults; the RAM needs no clearing pass.
// ----------------------------------------------------------------------------
module ring_bending_force_top (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start,
  output logic                                busy,
  input  logic signed [rbf_pkg::POS_W-1:0]    node_x_i,
  input  logic signed [rbf_pkg::POS_W-1:0]    node_y_i,
  input  logic signed [rbf_pkg::FORCE_W-1:0]  force_in_x_i,
  input  logic signed [rbf_pkg::FORCE_W-1:0]  force_in_y_i,
  input  logic                                last_node_i,
  output logic                                strobe_o,
  output logic signed [rbf_pkg::FORCE_W-1:0]  force_out_x_o,
  output logic signed [rbf_pkg::FORCE_W-1:0]  force_out_y_o,
  output logic                                last_out_o,
  input  logic                                cfg_we_i,
  input  logic [rbf_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [rbf_pkg::CFG_DATA_W-1:0]      cfg_data_i
);

  localparam int AW  = rbf_pkg::ADDR_W;
  localparam int CW  = rbf_pkg::CNT_W;
  localparam int RW  = rbf_pkg::RD_W;
  localparam int PW  = rbf_pkg::POS_W;
  localparam int FW  = rbf_pkg::FORCE_W;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_RUN  = 1'b1;

  logic                      state_q, state_d;
  logic [CW-1:0]             cnt_q, cnt_d;
  logic [CW-1:0]             n_q, n_d;
  logic [RW-1:0]             rd_cnt_q, rd_cnt_d;
  logic [AW-1:0]             rd_idx_q, rd_idx_d;
  logic [CW-1:0]             out_cnt_q, out_cnt_d;
  logic [1:0]                pseen_q, pseen_d;
  logic [1:0]                fseen_q, fseen_d;
  logic                      v1_q, v2_q, v3_q, v4_q;
  logic                      strobe_q, last_q;
  logic [rbf_pkg::STIFF_W-1:0] stiff_q;
  logic [rbf_pkg::CAP_W-1:0]   cap_q;

  logic                      accept, room, wr_en, rd_fire, final_out;
  logic [CW-1:0]             cnt_inc;
  logic [rbf_pkg::DATA_W-1:0] wdata, rdata;
  rbf_pkg::axis_ctrl_t       ctrl;

  assign accept  = start && !busy;
  assign room    = cnt_q < CW'(rbf_pkg::MAX_NODES);
  assign wr_en   = accept && room;
  assign cnt_inc = room ? cnt_q + CW'(1) : cnt_q;
  assign wdata   = {node_x_i, node_y_i, force_in_x_i, force_in_y_i};

  assign rd_fire = (state_q == ST_RUN) && (rd_cnt_q < (RW'(n_q) + RW'(4)));

  assign ctrl.pos_shift = v1_q;
  assign ctrl.d2_load   = v1_q && (pseen_q == 2'd2);
  assign ctrl.prod_load = v2_q;
  assign ctrl.f_load    = v3_q;
  assign ctrl.f_shift   = v4_q;
  assign ctrl.out_load  = v4_q && (fseen_q == 2'd2);

  assign final_out = ctrl.out_load && (out_cnt_q == n_q - CW'(1));

  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    n_d       = n_q;
    rd_cnt_d  = rd_cnt_q;
    rd_idx_d  = rd_idx_q;
    out_cnt_d = out_cnt_q;
    pseen_d   = pseen_q;
    fseen_d   = fseen_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (last_node_i) begin
            // sweep starts two nodes before node 0 so both wrap windows fill
            state_d   = ST_RUN;
            cnt_d     = '0;
            n_d       = cnt_inc;
            rd_cnt_d  = '0;
            rd_idx_d  = (cnt_inc == CW'(1)) ? '0 : AW'(cnt_inc - CW'(2));
            out_cnt_d = '0;
            pseen_d   = '0;
            fseen_d   = '0;
          end else begin
            cnt_d = cnt_inc;
          end
        end
      end
      ST_RUN: begin
        if (rd_fire) begin
          rd_cnt_d = rd_cnt_q + RW'(1);
          rd_idx_d = (CW'(rd_idx_q) == n_q - CW'(1)) ? '0 : rd_idx_q + AW'(1);
        end
        if (v1_q && (pseen_q != 2'd2)) begin
          pseen_d = pseen_q + 2'd1;
        end
        if (v4_q && (fseen_q != 2'd2)) begin
          fseen_d = fseen_q + 2'd1;
        end
        if (ctrl.out_load) begin
          out_cnt_d = out_cnt_q + CW'(1);
        end
        if (final_out) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      cnt_q     <= '0;
      n_q       <= '0;
      rd_cnt_q  <= '0;
      rd_idx_q  <= '0;
      out_cnt_q <= '0;
      pseen_q   <= '0;
      fseen_q   <= '0;
      v1_q      <= 1'b0;
      v2_q      <= 1'b0;
      v3_q      <= 1'b0;
      v4_q      <= 1'b0;
      strobe_q  <= 1'b0;
      last_q    <= 1'b0;
      stiff_q   <= '0;
      cap_q     <= rbf_pkg::CAP_RESET;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      n_q       <= n_d;
      rd_cnt_q  <= rd_cnt_d;
      rd_idx_q  <= rd_idx_d;
      out_cnt_q <= out_cnt_d;
      pseen_q   <= pseen_d;
      fseen_q   <= fseen_d;
      v1_q      <= rd_fire;
      v2_q      <= ctrl.d2_load;
      v3_q      <= v2_q;
      v4_q      <= v3_q;
      strobe_q  <= ctrl.out_load;
      last_q    <= final_out;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          rbf_pkg::CFG_BEND_STIFFNESS: stiff_q <= cfg_data_i[rbf_pkg::STIFF_W-1:0];
          rbf_pkg::CFG_FORCE_CAP:      cap_q   <= cfg_data_i[rbf_pkg::CAP_W-1:0];
          default: ;
        endcase
      end
    end
  end

  rbf_ram #(
    .WIDTH (rbf_pkg::DATA_W),
    .DEPTH (rbf_pkg::MAX_NODES)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (cnt_q[AW-1:0]),
    .wdata_i (wdata),
    .re_i    (rd_fire),
    .raddr_i (rd_idx_q),
    .rdata_o (rdata)
  );

  rbf_axis u_axis_x (
    .clk_i   (clk_i),
    .ctrl_i  (ctrl),
    .pos_i   (rdata[2*FW+2*PW-1:2*FW+PW]),
    .force_i (rdata[2*FW-1:FW]),
    .stiff_i (stiff_q),
    .cap_i   (cap_q),
    .force_o (force_out_x_o)
  );

  rbf_axis u_axis_y (
    .clk_i   (clk_i),
    .ctrl_i  (ctrl),
    .pos_i   (rdata[2*FW+PW-1:2*FW]),
    .force_i (rdata[FW-1:0]),
    .stiff_i (stiff_q),
    .cap_i   (cap_q),
    .force_o (force_out_y_o)
  );

  assign busy       = (state_q == ST_RUN);
  assign strobe_o   = strobe_q;
  assign last_out_o = last_q;

endmodule

### hw/rtl/rbf_checker.sv
// ----------------------------------------------------------------------------
// rbf_checker
// Port-level checks on the ring bending force block, bound to the top level.
// ----------------------------------------------------------------------------
module rbf_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic start,
  input logic busy,
  input logic last_node_i,
  input logic strobe_o,
  input logic last_out_o
);

  // a closing transaction always starts a sweep
  a_close_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy && last_node_i |=> busy)
    else $error("ring close did not raise busy");

  // results come only out of a sweep
  a_strobe_in_sweep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o |-> $past(busy))
    else $error("result outside a sweep");

  a_last_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    last_out_o |-> strobe_o)
    else $error("last flag without result");

  // the sweep ends exactly with the final result of the ring
  a_end_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy) |-> strobe_o && last_out_o)
    else $error("sweep ended without final result");

  a_start_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(busy) |-> !strobe_o)
    else $error("result at sweep start");

endmodule

bind ring_bending_force_top rbf_checker u_rbf_checker (.*);
